[rtl/core/ettf_pkg.sv]
`timescale 1ns / 1ps

package ettf_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int TYPE_W      = 32;

    localparam logic [1:0] KIND_LOAD     = 2'd0;
    localparam logic [1:0] KIND_DISABLE  = 2'd1;
    localparam logic [1:0] KIND_REENABLE = 2'd2;
    localparam logic [1:0] KIND_QUERY    = 2'd3;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // Broadcast to every cell of the chain
    typedef struct packed {
        logic              cmp;
        logic              wr_reg;
        logic              wr_dis;
        logic              shift;
        logic [TYPE_W-1:0] ev_type;
        logic [TYPE_W-1:0] group;
        logic [CNT_W-1:0]  wr_idx_reg;
        logic [CNT_W-1:0]  wr_idx_dis;
        logic [CNT_W-1:0]  reg_cnt;
        logic [CNT_W-1:0]  dis_cnt;
    } ctrl_t;

endpackage

[rtl/core/ettf_cell.sv]
`timescale 1ns / 1ps

module ettf_cell (
    input  logic                               clk,
    input  logic [ettf_pkg::IDX_W-1:0]         idx,
    input  ettf_pkg::ctrl_t                    ctrl,
    input  logic [ettf_pkg::TYPE_W-1:0]        dis_up,
    input  logic                               chain_in,
    output logic                               chain_out,
    output logic [ettf_pkg::TYPE_W-1:0]        dis_entry,
    output logic                               reg_hit,
    output logic                               dis_hit
);
    import ettf_pkg::*;

    logic [TYPE_W-1:0] reg_entry_reg;
    logic [TYPE_W-1:0] dis_entry_reg;
    logic              reg_hit_reg;
    logic              dis_hit_reg;
    logic [CNT_W-1:0]  idx_ext;
    logic              reg_valid;
    logic              dis_valid;

    assign idx_ext   = CNT_W'(idx);
    assign reg_valid = idx_ext < ctrl.reg_cnt;
    assign dis_valid = idx_ext < ctrl.dis_cnt;

    // this entry or one below it holds the type being removed
    assign chain_out = chain_in | dis_hit_reg;
    assign dis_entry = dis_entry_reg;
    assign reg_hit   = reg_hit_reg;
    assign dis_hit   = dis_hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.cmp)
        begin
            reg_hit_reg <= reg_valid && (reg_entry_reg == ctrl.ev_type ||
                                         reg_entry_reg == ctrl.group);
            dis_hit_reg <= dis_valid && (dis_entry_reg == ctrl.ev_type);
        end
        if (ctrl.wr_reg && idx_ext == ctrl.wr_idx_reg)
        begin
            reg_entry_reg <= ctrl.ev_type;
        end
        if (ctrl.wr_dis && idx_ext == ctrl.wr_idx_dis)
        begin
            dis_entry_reg <= ctrl.ev_type;
        end
        else if (ctrl.shift && chain_out)
        begin
            dis_entry_reg <= dis_up;
        end
    end

endmodule

[rtl/core/event_type_filter_table_top.sv]
`timescale 1ns / 1ps
// An accepted request is registered, its compare hits are registered in the compare pass
// through the chain of cells, and its result is registered onto m_tvalid in the update/shift
// pass. While a request is in flight, the next is taken only in the cycle its result commits.
// Reset (rst_n low, asynchronous): both table counts, the wildcard mask and all
// handshake state clear; table entries are left as they are until written.

module event_type_filter_table_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: wildcard_mask
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // request side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] event_type, [32] start_new_list, [39:33] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] status, [2] handled, [7:3] zero
);
    import ettf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_ACT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [TYPE_W-1:0] mask_reg;
    logic [1:0]        kind_reg;
    logic [TYPE_W-1:0] type_reg;
    logic              start_reg;
    logic [CNT_W-1:0]  reg_cnt_reg, reg_cnt_next;
    logic [CNT_W-1:0]  dis_cnt_reg, dis_cnt_next;
    logic              out_valid_reg;
    logic [1:0]        status_reg, status_next;
    logic              handled_reg, handled_next;

    logic              accept;
    logic              commit;
    logic              any_reg;
    logic              any_dis;
    logic [CNT_W-1:0]  load_base;
    ctrl_t             ctrl;

    logic [TABLE_DEPTH-1:0] reg_hits;
    logic [TABLE_DEPTH-1:0] dis_hits;
    logic [TABLE_DEPTH:0]   chain;
    logic [TYPE_W-1:0]      dis_entries [TABLE_DEPTH];

    // The mask register takes writes only while idle, so a pass never sees it change.
    assign cfg_ready = (state_reg == ST_IDLE);

    // Results wait in an output register; the next request may be taken
    // in the same cycle a result is committed.
    assign commit   = (state_reg == ST_ACT) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == ST_IDLE) || commit;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, handled_reg, status_reg};

    assign any_reg = |reg_hits;
    assign any_dis = |dis_hits;

    // A load with the start flag restarts both lists at entry zero
    assign load_base = start_reg ? '0 : reg_cnt_reg;

    // ---------------------------------------------------------------
    // Cell control for the compare pass and decision for the request in the act pass
    // ---------------------------------------------------------------
    always_comb
    begin
        ctrl            = '0;
        ctrl.cmp        = (state_reg == ST_CMP);
        ctrl.ev_type    = type_reg;
        ctrl.group      = type_reg | mask_reg;
        ctrl.reg_cnt    = reg_cnt_reg;
        ctrl.dis_cnt    = dis_cnt_reg;
        ctrl.wr_idx_reg = load_base;
        ctrl.wr_idx_dis = dis_cnt_reg;
        reg_cnt_next    = reg_cnt_reg;
        dis_cnt_next    = dis_cnt_reg;
        status_next     = STATUS_OK;
        handled_next    = 1'b0;
        unique case (kind_reg)
            KIND_LOAD:
            begin
                if (start_reg)
                begin
                    dis_cnt_next = '0;
                end
                if (load_base < CNT_W'(TABLE_DEPTH))
                begin
                    ctrl.wr_reg  = commit;
                    reg_cnt_next = load_base + CNT_W'(1);
                end
                else
                begin
                    status_next = STATUS_FULL;
                end
            end
            KIND_DISABLE:
            begin
                if (any_dis)
                begin
                    status_next = STATUS_OK;
                end
                else if (any_reg)
                begin
                    if (dis_cnt_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        ctrl.wr_dis  = commit;
                        dis_cnt_next = dis_cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        status_next = STATUS_FULL;
                    end
                end
                else
                begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            KIND_REENABLE:
            begin
                if (any_dis)
                begin
                    ctrl.shift   = commit;
                    dis_cnt_next = dis_cnt_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            KIND_QUERY:
            begin
                handled_next = !any_dis && any_reg;
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_ACT;
            ST_ACT:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
                else if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '0;
            reg_cnt_reg   <= '0;
            dis_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= cfg_data;
            end
            if (commit)
            begin
                reg_cnt_reg   <= reg_cnt_next;
                dis_cnt_reg   <= dis_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= s_tuser;
            type_reg  <= s_tdata[31:0];
            start_reg <= s_tdata[32];
        end
        if (commit)
        begin
            status_reg  <= status_next;
            handled_reg <= handled_next;
        end
    end

    // ---------------------------------------------------------------
    // Chain of cells: entry i of both lists lives in cell i. The hit
    // chain runs upward so every cell at or above the removed entry
    // takes its upper neighbour's value in the shift pass.
    // ---------------------------------------------------------------
    assign chain[0] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [TYPE_W-1:0] up;
        if (i == TABLE_DEPTH - 1)
        begin : g_top
            assign up = dis_entries[i];
        end
        else
        begin : g_mid
            assign up = dis_entries[i + 1];
        end

        ettf_cell u_cell (
            .clk       (clk),
            .idx       (IDX_W'(i)),
            .ctrl      (ctrl),
            .dis_up    (up),
            .chain_in  (chain[i]),
            .chain_out (chain[i + 1]),
            .dis_entry (dis_entries[i]),
            .reg_hit   (reg_hits[i]),
            .dis_hit   (dis_hits[i])
        );
    end

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_reg_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        reg_cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("registered count beyond table depth");

    a_dis_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        dis_cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("disabled count beyond table depth");

    // disabled list never holds a type twice
    a_dis_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACT) |-> $onehot0(dis_hits))
        else $error("duplicate entry in disabled list");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift |-> (dis_cnt_reg != '0))
        else $error("removal from empty disabled list");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule
